>>> rtl/trngh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trngh_pkg;

  // Block limits
  localparam int MaxBlockBits = 256;
  localparam int RunCutoff    = 16;

  // Field widths
  localparam int SampleWidth = 8;
  localparam int WordWidth   = 32;
  localparam int WordIdxW    = $clog2(WordWidth);
  localparam int CountWidth  = $clog2(MaxBlockBits + 1);
  localparam int RunWidth    = $clog2(RunCutoff + 2);

  // Output mode codes
  localparam logic ModeFold = 1'b0;
  localparam logic ModeRaw  = 1'b1;

  // End-of-block result between the accumulator and the output register
  typedef struct packed {
    logic [WordWidth-1:0] random_word;
    logic                 health_ok;
    logic                 run_failure;
    logic                 balance_failure;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/trngh_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface trngh_sample_if;
  logic                             valid;
  logic                             ready;
  logic [trngh_pkg::SampleWidth-1:0] raw_sample;
  logic                             block_end;

  modport source (output valid, output raw_sample, output block_end, input ready);
  modport sink (input valid, input raw_sample, input block_end, output ready);
endinterface

`default_nettype wire

>>> rtl/trngh_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface trngh_result_if;
  logic                            valid;
  logic                            ready;
  logic [trngh_pkg::WordWidth-1:0] random_word;
  logic                            health_ok;
  logic                            run_failure;
  logic                            balance_failure;

  modport source (output valid, output random_word, output health_ok,
                  output run_failure, output balance_failure, input ready);
  modport sink (input valid, input random_word, input health_ok,
                input run_failure, input balance_failure, output ready);
endinterface

`default_nettype wire

>>> rtl/trngh_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface trngh_cfg_if;
  logic valid;
  logic ready;
  logic output_mode;

  modport source (output valid, output output_mode, input ready);
  modport sink (input valid, input output_mode, output ready);
endinterface

`default_nettype wire

>>> rtl/trngh_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module trngh_accum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire logic              bit_i,
  input  wire logic              last_i,
  input  wire logic              mode_i,
  output trngh_pkg::result_t     result_o
);

  logic [trngh_pkg::CountWidth-1:0] bits_seen_q, bits_seen_d;
  logic [trngh_pkg::CountWidth-1:0] ones_q, ones_d;
  logic [trngh_pkg::RunWidth-1:0]   run_q, run_d;
  logic                             prev_q, prev_d;
  logic                             run_fail_q, run_fail_d;
  logic [trngh_pkg::WordWidth-1:0]  word_q, word_d;

  logic                             counting;
  logic [trngh_pkg::WordIdxW-1:0]   pos;
  logic [trngh_pkg::WordWidth-1:0]  bit_mask;
  logic [trngh_pkg::CountWidth+1:0] n_ext;
  logic [trngh_pkg::CountWidth+1:0] ones_ext;
  logic [trngh_pkg::CountWidth+1:0] lo_bound;
  logic [trngh_pkg::CountWidth+1:0] hi_bound;
  logic                             balance_fail;

  assign counting = bits_seen_q < trngh_pkg::CountWidth'(trngh_pkg::MaxBlockBits);
  assign pos      = bits_seen_q[trngh_pkg::WordIdxW-1:0];
  assign bit_mask = trngh_pkg::WordWidth'(bit_i) << pos;

  // Fold the new bit into the running counters and the word
  always_comb begin
    bits_seen_d = bits_seen_q;
    ones_d      = ones_q;
    run_d       = run_q;
    prev_d      = prev_q;
    run_fail_d  = run_fail_q;
    word_d      = word_q;
    if (counting) begin
      if (bits_seen_q == '0) begin
        run_d  = trngh_pkg::RunWidth'(1);
        prev_d = bit_i;
      end else if (bit_i == prev_q) begin
        if (run_q <= trngh_pkg::RunWidth'(trngh_pkg::RunCutoff)) begin
          run_d = run_q + trngh_pkg::RunWidth'(1);
        end
        if (run_d > trngh_pkg::RunWidth'(trngh_pkg::RunCutoff)) begin
          run_fail_d = 1'b1;
        end
      end else begin
        run_d  = trngh_pkg::RunWidth'(1);
        prev_d = bit_i;
      end
      ones_d = ones_q + trngh_pkg::CountWidth'(bit_i);
      if (mode_i == trngh_pkg::ModeRaw) begin
        if (bits_seen_q < trngh_pkg::CountWidth'(trngh_pkg::WordWidth)) begin
          word_d = word_q | bit_mask;
        end
      end else begin
        word_d = word_q ^ bit_mask;
      end
      bits_seen_d = bits_seen_q + trngh_pkg::CountWidth'(1);
    end
  end

  // Check the ones count against floor(n/4) and floor(3n/4)
  assign n_ext        = (trngh_pkg::CountWidth+2)'(bits_seen_d);
  assign ones_ext     = (trngh_pkg::CountWidth+2)'(ones_d);
  assign lo_bound     = n_ext >> 2;
  assign hi_bound     = ((n_ext << 1) + n_ext) >> 2;
  assign balance_fail = (ones_ext < lo_bound) || (ones_ext > hi_bound);

  always_comb begin
    result_o.random_word     = word_d;
    result_o.run_failure     = run_fail_d;
    result_o.balance_failure = balance_fail;
    result_o.health_ok       = !run_fail_d && !balance_fail;
  end

  // Commit on each advancing beat, clear at block end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_seen_q <= '0;
      ones_q      <= '0;
      run_q       <= '0;
      prev_q      <= 1'b0;
      run_fail_q  <= 1'b0;
      word_q      <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        bits_seen_q <= '0;
        ones_q      <= '0;
        run_q       <= '0;
        prev_q      <= 1'b0;
        run_fail_q  <= 1'b0;
        word_q      <= '0;
      end else begin
        bits_seen_q <= bits_seen_d;
        ones_q      <= ones_d;
        run_q       <= run_d;
        prev_q      <= prev_d;
        run_fail_q  <= run_fail_d;
        word_q      <= word_d;
      end
    end
  end

  // Counters stay within their limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_seen_q <= trngh_pkg::CountWidth'(trngh_pkg::MaxBlockBits))
    else $error("bits_seen past block limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ones_q <= bits_seen_q)
    else $error("ones count exceeds bits seen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= trngh_pkg::RunWidth'(trngh_pkg::RunCutoff + 1))
    else $error("run length past saturation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q > trngh_pkg::RunWidth'(trngh_pkg::RunCutoff) |-> run_fail_q)
    else $error("long run without failure flag");

endmodule

`default_nettype wire

>>> rtl/trng_health_test_and_fold_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Health tests and word folding for blocks of raw noise samples. One sample
// is taken every clock unless the sample channel stalls; bit 0 of each of
// the first 256 samples of a block feeds a repetition-count test (run
// longer than 16 fails), a ones-balance test and the 32-bit word. The beat
// marked block_end produces one result through an input register, the
// combinational counter update and an output register. Only a final sample
// can wait in the input register, and only while an earlier result is
// still held downstream; the sample channel then stalls, never otherwise.
// output_mode must be written over the config channel only while no block
// is in progress (the block does not enforce it); cfg_if is always ready.
module trng_health_test_and_fold_top (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  trngh_sample_if.sink   sample_if,
  trngh_cfg_if.sink      cfg_if,
  trngh_result_if.source result_if
);

  logic               in_vld_q;
  logic               in_bit_q;
  logic               in_last_q;
  logic               mode_q;
  logic               out_vld_q;
  trngh_pkg::result_t out_q;
  trngh_pkg::result_t result;
  logic               out_free;
  logic               stage_go;

  assign out_free        = !out_vld_q || result_if.ready;
  assign stage_go        = in_vld_q && (!in_last_q || out_free);
  assign sample_if.ready = !in_vld_q || stage_go;
  assign cfg_if.ready    = 1'b1;

  // Capture incoming sample beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_if.ready) begin
      in_vld_q <= sample_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_if.valid && sample_if.ready) begin
      in_bit_q  <= sample_if.raw_sample[0];
      in_last_q <= sample_if.block_end;
    end
  end

  // Hold the output mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= trngh_pkg::ModeFold;
    end else if (cfg_if.valid) begin
      mode_q <= cfg_if.output_mode;
    end
  end

  trngh_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (stage_go),
    .bit_i     (in_bit_q),
    .last_i    (in_last_q),
    .mode_i    (mode_q),
    .result_o  (result)
  );

  // Load the result beat at block end, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stage_go && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (result_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && in_last_q) begin
      out_q <= result;
    end
  end

  assign result_if.valid           = out_vld_q;
  assign result_if.random_word     = out_q.random_word;
  assign result_if.health_ok       = out_q.health_ok;
  assign result_if.run_failure     = out_q.run_failure;
  assign result_if.balance_failure = out_q.balance_failure;

  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stage_go && in_last_q && out_vld_q && !result_if.ready))
    else $error("result overwritten while stalled");

  // Non-final samples always move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !in_last_q |-> stage_go)
    else $error("non-final sample stalled");

  // A result appears only after a final sample advanced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(stage_go && in_last_q))
    else $error("result without block end");

  // Health flag agrees with the two test flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.health_ok == !(out_q.run_failure || out_q.balance_failure)))
    else $error("health flag inconsistent");

endmodule

`default_nettype wire

>>> tb/sv/tb_trng_health_test_and_fold_top.sv
`timescale 1ns / 1ps

module tb_trng_health_test_and_fold_top;

  localparam int NumPhases   = 5;
  localparam int PhaseBudget = 190;
  localparam int MinBlocks   = 2;
  localparam int IdleLimit   = 4000;
  localparam int SettleTicks = 6;

  typedef struct packed {
    logic [trngh_pkg::SampleWidth-1:0] raw;
    logic                              last;
  } noise_beat_t;

  logic clk_i;
  logic rst_ni;

  trngh_sample_if sample_bus ();
  trngh_cfg_if    cfg_bus ();
  trngh_result_if result_bus ();

  trng_health_test_and_fold_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_if (sample_bus),
    .cfg_if    (cfg_bus),
    .result_if (result_bus)
  );

  // Stimulus and expectation stores
  noise_beat_t        pending_beats[$];
  noise_beat_t        staged_beat;
  trngh_pkg::result_t expected_blocks[$];

  // Predictor state, mirroring one block in flight
  logic                             fold_mode;
  logic [trngh_pkg::CountWidth-1:0] bits_taken;
  logic [trngh_pkg::RunWidth-1:0]   run_len;
  logic                             last_bit;
  logic                             run_tripped;
  logic [trngh_pkg::CountWidth-1:0] ones_taken;
  logic [trngh_pkg::WordWidth-1:0]  word_acc;

  int sender_idle_pct;
  int sink_stall_pct;
  int error_count;
  int beats_sent;
  int blocks_checked;
  int overflow_blocks;
  int idle_cycles;

  int phase_idle  [NumPhases] = '{0, 78, 0, 32, 0};
  int phase_stall [NumPhases] = '{0, 0, 78, 32, 0};
  logic phase_mode [NumPhases] = '{trngh_pkg::ModeFold, trngh_pkg::ModeRaw,
                                   trngh_pkg::ModeFold, trngh_pkg::ModeRaw,
                                   trngh_pkg::ModeFold};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Report one field mismatch and count it
  task automatic report_mismatch(input string what,
                                 input logic [trngh_pkg::WordWidth-1:0] got,
                                 input logic [trngh_pkg::WordWidth-1:0] want);
    $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Fold one accepted sample into the running block; on block end push the result
  task automatic absorb_sample(input logic [trngh_pkg::SampleWidth-1:0] raw,
                               input logic last);
    logic               bit_in;
    int                 n;
    int                 lo;
    int                 hi;
    trngh_pkg::result_t res;
    bit_in = raw[0];
    if (bits_taken < trngh_pkg::CountWidth'(trngh_pkg::MaxBlockBits)) begin
      if (bits_taken == '0) begin
        run_len  = trngh_pkg::RunWidth'(1);
        last_bit = bit_in;
      end else if (bit_in == last_bit) begin
        if (run_len <= trngh_pkg::RunWidth'(trngh_pkg::RunCutoff))
          run_len = run_len + trngh_pkg::RunWidth'(1);
        if (run_len > trngh_pkg::RunWidth'(trngh_pkg::RunCutoff)) run_tripped = 1'b1;
      end else begin
        run_len  = trngh_pkg::RunWidth'(1);
        last_bit = bit_in;
      end
      ones_taken = ones_taken + trngh_pkg::CountWidth'(bit_in);
      if (fold_mode == trngh_pkg::ModeRaw) begin
        if (bits_taken < trngh_pkg::CountWidth'(trngh_pkg::WordWidth))
          word_acc[bits_taken[trngh_pkg::WordIdxW-1:0]] |= bit_in;
      end else begin
        word_acc[bits_taken[trngh_pkg::WordIdxW-1:0]] ^= bit_in;
      end
      bits_taken = bits_taken + trngh_pkg::CountWidth'(1);
    end
    if (last) begin
      n  = int'(bits_taken);
      lo = n / 4;
      hi = (3 * n) / 4;
      res.random_word     = word_acc;
      res.run_failure     = run_tripped;
      res.balance_failure = (int'(ones_taken) < lo) || (int'(ones_taken) > hi);
      res.health_ok       = !res.run_failure && !res.balance_failure;
      expected_blocks.push_back(res);
      if (n == trngh_pkg::MaxBlockBits) overflow_blocks++;
      bits_taken  = '0;
      run_len     = '0;
      last_bit    = 1'b0;
      run_tripped = 1'b0;
      ones_taken  = '0;
      word_acc    = '0;
    end
  endtask

  // Queue whole blocks with random length and bit pattern until the budget is spent and MinBlocks are queued
  task automatic queue_random_blocks(input int budget, input bit with_overflow);
    int   queued;
    int   blocks;
    int   len;
    int   pick;
    int   style;
    int   run_left;
    logic run_val;
    logic b;
    queued = 0;
    blocks = 0;
    while (queued < budget || blocks < MinBlocks) begin
      pick = $urandom_range(99);
      if (with_overflow && blocks == 0)
        len = $urandom_range(trngh_pkg::MaxBlockBits + 34, trngh_pkg::MaxBlockBits);
      else if (pick < 80) len = $urandom_range(24, 1);
      else if (pick < 94) len = $urandom_range(trngh_pkg::MaxBlockBits, 25);
      else len = $urandom_range(trngh_pkg::MaxBlockBits + 34, trngh_pkg::MaxBlockBits + 1);
      style    = $urandom_range(3);
      run_val  = 1'($urandom_range(1));
      run_left = 0;
      for (int i = 0; i < len; i++) begin
        case (style)
          0: b = 1'($urandom_range(1));
          1: b = ($urandom_range(99) < 90);
          2: b = ($urandom_range(99) < 10);
          default: begin
            // alternate runs, some long enough to trip the run test
            if (run_left == 0) begin
              run_val  = ~run_val;
              run_left = $urandom_range(20, 1);
            end
            run_left--;
            b = run_val;
          end
        endcase
        pending_beats.push_back('{raw: {7'($urandom), b}, last: (i == len - 1)});
      end
      queued += len;
      blocks++;
    end
  endtask

  // Hold until every queued beat is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || sample_bus.valid || expected_blocks.size() != 0);
  endtask

  // Sample driver: advance to the next queued beat after each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_bus.valid      <= 1'b0;
      sample_bus.raw_sample <= '0;
      sample_bus.block_end  <= 1'b0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        absorb_sample(sample_bus.raw_sample, sample_bus.block_end);
        beats_sent++;
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          staged_beat           = pending_beats.pop_front();
          sample_bus.valid      <= 1'b1;
          sample_bus.raw_sample <= staged_beat.raw;
          sample_bus.block_end  <= staged_beat.last;
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("result with no block pending", result_bus.random_word, '0);
        end else begin
          if (result_bus.random_word !== expected_blocks[0].random_word)
            report_mismatch("random_word", result_bus.random_word,
                            expected_blocks[0].random_word);
          if (result_bus.health_ok !== expected_blocks[0].health_ok)
            report_mismatch("health_ok",
                            trngh_pkg::WordWidth'(result_bus.health_ok),
                            trngh_pkg::WordWidth'(expected_blocks[0].health_ok));
          if (result_bus.run_failure !== expected_blocks[0].run_failure)
            report_mismatch("run_failure",
                            trngh_pkg::WordWidth'(result_bus.run_failure),
                            trngh_pkg::WordWidth'(expected_blocks[0].run_failure));
          if (result_bus.balance_failure !== expected_blocks[0].balance_failure)
            report_mismatch("balance_failure",
                            trngh_pkg::WordWidth'(result_bus.balance_failure),
                            trngh_pkg::WordWidth'(expected_blocks[0].balance_failure));
          void'(expected_blocks.pop_front());
          blocks_checked++;
        end
      end
      result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: drop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni                = 1'b0;
    sample_bus.valid      = 1'b0;
    sample_bus.raw_sample = '0;
    sample_bus.block_end  = 1'b0;
    result_bus.ready      = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.output_mode   = trngh_pkg::ModeFold;
    fold_mode             = trngh_pkg::ModeFold;
    bits_taken            = '0;
    run_len               = '0;
    last_bit              = 1'b0;
    run_tripped           = 1'b0;
    ones_taken            = '0;
    word_acc              = '0;
    sender_idle_pct       = 0;
    sink_stall_pct        = 0;
    error_count           = 0;
    beats_sent            = 0;
    blocks_checked        = 0;
    overflow_blocks       = 0;
    idle_cycles           = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      // Write the mode only between blocks, once the pipe has settled
      if (p > 0) begin
        repeat (SettleTicks) @(posedge clk_i);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.output_mode <= phase_mode[p];
        do @(posedge clk_i);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        fold_mode = phase_mode[p];
      end
      sender_idle_pct = phase_idle[p];
      sink_stall_pct  = phase_stall[p];

      if (p == 0) begin
        // single-sample blocks: one failing bias, one passing, upper bits set
        pending_beats.push_back('{raw: 8'hFF, last: 1'b1});
        pending_beats.push_back('{raw: 8'hFE, last: 1'b1});
        // run of 18 ones trips the run test and the bias test
        for (int i = 0; i < 18; i++)
          pending_beats.push_back('{raw: {7'($urandom), 1'b1}, last: (i == 17)});
        // balanced short block with zero upper bits
        for (int i = 0; i < 4; i++)
          pending_beats.push_back('{raw: {7'h00, i[0]}, last: (i == 3)});
      end

      // force a block at or past the sample cap in the raw-mode phases
      queue_random_blocks(PhaseBudget, p[0]);
      wait_drained();
    end

    repeat (SettleTicks) @(posedge clk_i);
    if (expected_blocks.size() != 0)
      report_mismatch("results never delivered", '0,
                      trngh_pkg::WordWidth'(expected_blocks.size()));

    $display("Covered %0d samples and %0d checked blocks (%0d at the sample cap),",
             beats_sent, blocks_checked, overflow_blocks);
    $display("in fold and raw modes under sender idling and receiver stalls.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
